// ----- sv/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// String escape decoder package
// Shared payload types, decode state and the result bundle that moves from
// the decode logic to the output queue.
// ----------------------------------------------------------------------------
package sed_pkg;

   // Decode modes of the escape state machine.
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_OCT1   = 3'd2,
      MODE_OCT2   = 3'd3,
      MODE_HEX1   = 3'd4,
      MODE_HEX2   = 3'd5
   } sed_mode_type;

   // One raw byte of the literal body.
   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } sed_req_type;

   // One decoded byte of the string value.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } sed_rsp_type;

   // Decoder state carried from one input byte to the next.
   typedef struct packed {
      sed_mode_type mode;
      logic [7:0]   held_char;
      logic [8:0]   octal_accum;
   } sed_state_type;

   // Up to three decoded bytes produced by one input byte.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } sed_res_type;

endpackage

// ----- sv/sed_decode.sv -----
// ----------------------------------------------------------------------------
// String escape decode step
// Combinational next-state and result logic for one raw input byte: plain
// text, simple escapes, octal escapes and two-character hex escapes.
// ----------------------------------------------------------------------------
module sed_decode (
   input  sed_pkg::sed_state_type state_cur,
   input  sed_pkg::sed_req_type   req,
   output sed_pkg::sed_state_type state_nxt,
   output sed_pkg::sed_res_type   res
);
   import sed_pkg::*;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   // Appends one byte to the result bundle.
   function automatic sed_res_type res_put(input sed_res_type r, input logic [7:0] v);
      sed_res_type o;
      o = r;
      if (r.count != 2'd3) begin
         o.bytes[r.count] = v;
         o.count          = r.count + 2'd1;
      end
      return o;
   endfunction

   // Hex digit value, with a valid flag in the top bit.
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= CH_0 && ch <= CH_9) begin
         r = {1'b1, 4'(ch - CH_0)};
      end else if (ch >= CH_LA && ch <= CH_LF) begin
         r = {1'b1, 4'(ch - CH_LA + 8'd10)};
      end else if (ch >= CH_UA && ch <= CH_UF) begin
         r = {1'b1, 4'(ch - CH_UA + 8'd10)};
      end
      return r;
   endfunction

   // Control byte for a simple escape; other bytes pass unchanged.
   function automatic logic [7:0] simple_escape(input logic [7:0] ch);
      logic [7:0] r;
      case (ch)
         8'h6e:   r = 8'd10;  // n
         8'h74:   r = 8'd9;   // t
         8'h72:   r = 8'd13;  // r
         8'h61:   r = 8'd7;   // a
         8'h62:   r = 8'd8;   // b
         8'h66:   r = 8'd12;  // f
         8'h76:   r = 8'd11;  // v
         default: r = ch;
      endcase
      return r;
   endfunction

   logic [7:0] c;
   logic       last;
   logic       is_oct;
   logic [4:0] hd_a;
   logic [4:0] hd_b;
   logic       a_space;
   logic       hex_ok;
   logic [7:0] hex_val;
   logic       do_feed;

   assign c      = req.in_char;
   assign last   = req.in_last;
   assign is_oct = (c >= CH_0) && (c <= CH_7);

   // Base-16 parse of the held byte followed by the current byte.
   always_comb begin
      hd_a    = hex_digit(state_cur.held_char);
      hd_b    = hex_digit(c);
      a_space = (state_cur.held_char == CH_SPACE) ||
                (state_cur.held_char >= CH_TAB && state_cur.held_char <= CH_CR);
      hex_ok  = 1'b0;
      hex_val = 8'd0;
      if (a_space || state_cur.held_char == CH_PLUS) begin
         hex_ok  = hd_b[4];
         hex_val = {4'd0, hd_b[3:0]};
      end else if (state_cur.held_char == CH_MINUS) begin
         hex_ok  = hd_b[4];
         hex_val = 8'(8'd0 - {4'd0, hd_b[3:0]});
      end else if (hd_a[4]) begin
         hex_ok  = 1'b1;
         hex_val = hd_b[4] ? {hd_a[3:0], hd_b[3:0]} : {4'd0, hd_a[3:0]};
      end
   end

   // Main step: finish a pending hex escape, then decode the current byte.
   always_comb begin
      sed_state_type st;
      sed_res_type   r;
      st      = state_cur;
      r       = '0;
      do_feed = 1'b1;

      // A failed hex escape emits 'x' and replays the held byte as text.
      if (state_cur.mode == MODE_HEX2) begin
         st.mode = MODE_NORMAL;
         if (hex_ok) begin
            r       = res_put(r, hex_val);
            do_feed = 1'b0;
         end else begin
            r = res_put(r, CH_X);
            if (state_cur.held_char == CH_BSL) begin
               st.mode = MODE_ESC;
            end else begin
               r = res_put(r, state_cur.held_char);
            end
         end
      end

      if (do_feed) begin
         unique case (st.mode)
            MODE_ESC: begin
               st.mode = MODE_NORMAL;
               if (c == CH_X) begin
                  if (last) begin
                     r = res_put(r, CH_X);
                  end else begin
                     st.mode = MODE_HEX1;
                  end
               end else if (is_oct) begin
                  st.octal_accum = {6'd0, c[2:0]};
                  if (last) begin
                     r = res_put(r, st.octal_accum[7:0]);
                  end else begin
                     st.mode = MODE_OCT1;
                  end
               end else begin
                  r = res_put(r, simple_escape(c));
               end
            end
            MODE_OCT1, MODE_OCT2: begin
               if (is_oct) begin
                  st.octal_accum = {st.octal_accum[5:0], c[2:0]};
                  if (st.mode == MODE_OCT2 || last) begin
                     r       = res_put(r, st.octal_accum[7:0]);
                     st.mode = MODE_NORMAL;
                  end else begin
                     st.mode = MODE_OCT2;
                  end
               end else begin
                  // A non-octal byte closes the escape and is decoded as text.
                  r = res_put(r, st.octal_accum[7:0]);
                  if (c == CH_BSL && !last) begin
                     st.mode = MODE_ESC;
                  end else begin
                     st.mode = MODE_NORMAL;
                     r       = res_put(r, c);
                  end
               end
            end
            MODE_HEX1: begin
               if (last) begin
                  // Literal ends right after backslash x and one byte.
                  r       = res_put(r, CH_X);
                  st.mode = MODE_NORMAL;
                  r       = res_put(r, c);
               end else begin
                  st.held_char = c;
                  st.mode      = MODE_HEX2;
               end
            end
            default: begin
               if (c == CH_BSL && !last) begin
                  st.mode = MODE_ESC;
               end else begin
                  st.mode = MODE_NORMAL;
                  r       = res_put(r, c);
               end
            end
         endcase
      end

      // The final byte of a literal returns all state to its reset value.
      if (last) begin
         st.mode        = MODE_NORMAL;
         st.held_char   = 8'd0;
         st.octal_accum = 9'd0;
      end

      state_nxt = st;
      res       = r;
   end

endmodule

// ----- sv/string_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// String escape decoder
// Decodes the body of a C string literal, one raw byte per transfer, into
// the bytes of the string value.
// ----------------------------------------------------------------------------
// Each input byte is decoded in the cycle it is accepted and its results
// (zero to three bytes) land in a three-entry output queue, so results are on
// offer from the cycle after the input transfer. The block accepts one byte
// per cycle while each byte yields at most one result and rsp_ready stays
// high; a byte that yields two or three results (a failed or cut-short hex
// escape, or an octal escape closed by a plain byte) holds the queue for that
// many output transfers; the input waits until the last of them is being taken.
module string_escape_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sed_pkg::sed_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sed_pkg::sed_rsp_type rsp_data
);
   import sed_pkg::*;

   sed_state_type   state_ff;
   sed_state_type   state_in;
   sed_res_type     dec_res;
   logic [2:0][7:0] queue_ff;
   logic [2:0][7:0] queue_in;
   logic [1:0]      rem_ff;
   logic [1:0]      rem_in;
   logic            end_ff;
   logic            end_in;
   logic            req_xfer;
   logic            rsp_xfer;

   // Escape decode for the byte on the input channel.
   sed_decode u_decode (
      .state_cur (state_ff),
      .req       (req_data),
      .state_nxt (state_in),
      .res       (dec_res)
   );

   // Input is taken once the queue is empty or its last entry leaves now.
   assign rsp_valid = (rem_ff != 2'd0);
   assign req_ready = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // Output queue: load on an input transfer, shift on an output transfer.
   always_comb begin
      queue_in = queue_ff;
      rem_in   = rem_ff;
      end_in   = end_ff;
      if (req_xfer) begin
         queue_in = dec_res.bytes;
         rem_in   = dec_res.count;
         end_in   = req_data.in_last;
      end else if (rsp_xfer) begin
         queue_in = {8'd0, queue_ff[2], queue_ff[1]};
         rem_in   = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_NORMAL, held_char: 8'd0, octal_accum: 9'd0};
         rem_ff   <= 2'd0;
         end_ff   <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         rem_ff <= rem_in;
         end_ff <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // The head of the queue is the result on offer.
   assign rsp_data.out_byte   = queue_ff[0];
   assign rsp_data.run_last   = (rem_ff == 2'd1);
   assign rsp_data.string_end = (rem_ff == 2'd1) && end_ff;

endmodule

// ----- sv/sed_checker.sv -----
// ----------------------------------------------------------------------------
// String escape decoder checker
// Port-level checks on the string escape decoder, attached by a bind.
// ----------------------------------------------------------------------------
module sed_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sed_pkg::sed_rsp_type rsp_data
);

   // A stalled result keeps its value until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The end of the literal is always the last result of its input byte.
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |-> rsp_data.run_last)
      else $error("string_end without run_last");

   // More results of the same byte pending: no new input is taken.
   a_no_take_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> !req_ready)
      else $error("input ready while a multi-byte run is pending");

   // Input is held off only by pending results.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input not ready with no result pending");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// String escape decoder testbench
// Feeds literal bodies through the decoder with random idle cycles on both
// channels, predicts every decoded byte in step with each input transfer and
// compares the result transfers, in order, against those predictions.
// ----------------------------------------------------------------------------
module testbench;
   import sed_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned RANDOM_ITEMS = 410;

   // Characters that steer the escape decoding.
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_0      = "0";
   localparam logic [7:0] CH_7      = "7";
   localparam logic [7:0] CH_9      = "9";
   localparam logic [7:0] CH_LA     = "a";
   localparam logic [7:0] CH_LF     = "f";
   localparam logic [7:0] CH_UA     = "A";
   localparam logic [7:0] CH_UF     = "F";
   localparam logic [7:0] CH_X      = "x";
   localparam logic [7:0] CH_N      = "n";
   localparam logic [7:0] CH_T      = "t";
   localparam logic [7:0] CH_R      = "r";
   localparam logic [7:0] CH_B      = "b";
   localparam logic [7:0] CH_V      = "v";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sed_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sed_rsp_type rsp_data;

   // Raw literal bytes waiting to be sent, and decoded bytes still due.
   sed_req_type raw_bytes[$];
   sed_rsp_type decoded_due[$];

   // Predicted decoder state.
   sed_mode_type esc_mode = MODE_NORMAL;
   logic [7:0]   hex_first = '0;
   logic [8:0]   oct_value = '0;
   logic [7:0]   step_bytes[$];

   int unsigned total_items = 0;
   int unsigned accepted_items = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_gap = 0;
   int unsigned recv_calm = 0;
   int unsigned hold_left = 0;
   int unsigned rsp_taken = 0;
   bit          hold_done = 1'b0;
   sed_rsp_type want;

   string_escape_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, a few long, with calm stretches.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 63) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic void emit(logic [7:0] b);
      if (step_bytes.size() < 3) step_bytes.push_back(b);
   endfunction

   // Plain text: a backslash opens an escape unless it ends the literal.
   function automatic void feed_plain(logic [7:0] c, logic last);
      if (c == CH_BSLASH && !last) begin
         esc_mode = MODE_ESC;
      end else begin
         esc_mode = MODE_NORMAL;
         emit(c);
      end
   endfunction

   // One byte in any mode other than the second hex byte.
   function automatic void feed_char(logic [7:0] c, logic last);
      logic is_oct;
      is_oct = (c >= CH_0 && c <= CH_7);
      case (esc_mode)
         MODE_ESC: begin
            esc_mode = MODE_NORMAL;
            if (c == CH_X) begin
               if (last) emit(CH_X);
               else esc_mode = MODE_HEX1;
            end else if (is_oct) begin
               oct_value = 9'(c - CH_0);
               if (last) emit(oct_value[7:0]);
               else esc_mode = MODE_OCT1;
            end else begin
               // Simple escapes map to control bytes; anything else passes.
               case (c)
                  CH_N:    emit(8'h0A);
                  CH_T:    emit(8'h09);
                  CH_R:    emit(8'h0D);
                  CH_LA:   emit(8'h07);
                  CH_B:    emit(8'h08);
                  CH_LF:   emit(8'h0C);
                  CH_V:    emit(8'h0B);
                  default: emit(c);
               endcase
            end
         end
         MODE_OCT1, MODE_OCT2: begin
            if (is_oct) begin
               oct_value = {oct_value[5:0], 3'(c - CH_0)};
               if (esc_mode == MODE_OCT2 || last) begin
                  emit(oct_value[7:0]);
                  esc_mode = MODE_NORMAL;
               end else begin
                  esc_mode = MODE_OCT2;
               end
            end else begin
               // A non-octal byte closes the escape and is decoded as text.
               emit(oct_value[7:0]);
               feed_plain(c, last);
            end
         end
         MODE_HEX1: begin
            if (last) begin
               emit(CH_X);
               feed_plain(c, last);
            end else begin
               hex_first = c;
               esc_mode = MODE_HEX2;
            end
         end
         default: feed_plain(c, last);
      endcase
   endfunction

   // Predicts the decoded bytes of one input transfer.
   function automatic void decode_transfer(logic [7:0] c, logic last);
      logic [7:0] first;
      logic [7:0] v;
      int         hi;
      int         lo;
      bit         ok;
      step_bytes.delete();
      if (esc_mode == MODE_HEX2) begin
         first = hex_first;
         esc_mode = MODE_NORMAL;
         hi = hex_val(first);
         lo = hex_val(c);
         ok = 1'b1;
         v = '0;
         // Base-16 parse of two bytes: leading blank or sign, then digits.
         if (first == CH_SPACE || (first >= CH_TAB && first <= CH_CR)) begin
            ok = (lo >= 0);
            v = 8'(lo);
         end else if (first == CH_PLUS || first == CH_MINUS) begin
            ok = (lo >= 0);
            v = (first == CH_MINUS) ? 8'(256 - lo) : 8'(lo);
         end else if (hi >= 0) begin
            v = (lo >= 0) ? 8'(hi * 16 + lo) : 8'(hi);
         end else begin
            ok = 1'b0;
         end
         if (ok) begin
            emit(v);
         end else begin
            // Failed hex escape: emit x and decode both bytes again.
            emit(CH_X);
            feed_char(first, 1'b0);
            feed_char(c, last);
         end
      end else begin
         feed_char(c, last);
      end
      if (last) begin
         esc_mode = MODE_NORMAL;
         hex_first = '0;
         oct_value = '0;
      end
      foreach (step_bytes[k]) begin
         want.out_byte = step_bytes[k];
         want.run_last = (k == step_bytes.size() - 1);
         want.string_end = want.run_last && last;
         decoded_due.push_back(want);
      end
   endfunction

   task automatic queue_body(input logic [7:0] body[$]);
      sed_req_type item;
      foreach (body[i]) begin
         item.in_char = body[i];
         item.in_last = (i == body.size() - 1);
         raw_bytes.push_back(item);
      end
   endtask

   task automatic queue_text(input string s);
      logic [7:0] body[$];
      for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
      queue_body(body);
   endtask

   // Byte for a hex escape: mostly digits, also blanks, signs and noise.
   function automatic logic [7:0] pick_hex_char();
      string digits;
      int unsigned r;
      digits = "0123456789abcdefABCDEF";
      r = $urandom_range(0, 99);
      if (r < 50) return digits[$urandom_range(0, 21)];
      if (r < 62) begin
         r = $urandom_range(8, 13);
         return (r == 8) ? CH_SPACE : 8'(r);
      end
      if (r < 77) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      return 8'($urandom_range(0, 255));
   endfunction

   // Stimulus: directed literals, then random literals, then the end check.
   initial begin
      logic [7:0] body[$];
      string      simple;
      int unsigned r;
      int unsigned cut;
      simple = "ntrabfv\\\"'?q";

      body = '{8'h00, 8'hFF};
      queue_body(body);
      queue_text("\\n");
      queue_text("\\x-1");
      queue_text("\\xzz");
      queue_text("\\xA");
      queue_text("\\");
      queue_text("\\1234");
      queue_text("\\7");
      queue_text("\\18");

      while (raw_bytes.size() < RANDOM_ITEMS) begin
         body.delete();
         if ($urandom_range(0, 9) == 0) begin
            // Noise literal of arbitrary bytes.
            repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               r = $urandom_range(0, 99);
               if (r < 35) begin
                  body.push_back(8'($urandom_range(0, 255)));
               end else if (r < 50) begin
                  body.push_back(CH_BSLASH);
                  body.push_back(simple[$urandom_range(0, simple.len() - 1)]);
               end else if (r < 65) begin
                  body.push_back(CH_BSLASH);
                  repeat ($urandom_range(1, 3)) body.push_back(CH_0 + 8'($urandom_range(0, 7)));
               end else if (r < 90) begin
                  body.push_back(CH_BSLASH);
                  body.push_back(CH_X);
                  body.push_back(pick_hex_char());
                  body.push_back(pick_hex_char());
               end else begin
                  body.push_back(CH_BSLASH);
                  body.push_back(8'($urandom_range(0, 255)));
               end
            end
            // Some literals end in the middle of an escape.
            if ($urandom_range(0, 99) < 15) begin
               cut = $urandom_range(1, body.size());
               while (body.size() > cut) void'(body.pop_back());
            end
         end
         queue_body(body);
      end
      total_items = raw_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (accepted_items != total_items || decoded_due.size() != 0);
      repeat (12) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Sender: offers queued bytes, with random gaps after each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (raw_bytes.size() > 0) begin
            req_data <= raw_bytes.pop_front();
            req_valid <= 1'b1;
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_taken >= 150) begin
            hold_done = 1'b1;
            hold_left = 120;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            recv_gap = pick_gap(recv_calm);
            rsp_ready <= (recv_gap == 0);
            if (recv_gap > 0) recv_gap--;
         end
      end
   end

   // Monitor: predicts on each input transfer, checks each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_transfer(req_data.in_char, req_data.in_last);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_due.size() == 0) begin
               $error("unexpected result: out_byte %02h with nothing outstanding",
                      rsp_data.out_byte);
               mismatches++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h",
                         want.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b",
                         want.run_last, rsp_data.run_last);
                  mismatches++;
               end
               if (rsp_data.string_end !== want.string_end) begin
                  $error("string_end: expected %0b, got %0b",
                         want.string_end, rsp_data.string_end);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
